>>> src/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int MAX_BURST_DEF = 8;
  localparam logic [7:0] DEV_ADDR_RESET = 8'hA6;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_BURST = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       rd_last;
    logic       ack_valid;
    logic       slave_nack;
  } res_t;

endpackage
`default_nettype wire

>>> src/i2cm_if.sv
`default_nettype none
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] reg_addr;
  logic [7:0] wr_data;
  logic [3:0] burst_len;
  logic       sda_in;
  modport source (output valid, req_type, reg_addr, wr_data, burst_len, sda_in, input ready);
  modport sink (input valid, req_type, reg_addr, wr_data, burst_len, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       busy_res;
  logic       rd_valid;
  logic [7:0] rd_data;
  logic       rd_last;
  logic       ack_valid;
  logic       slave_nack;
  modport source (output valid, scl, sda_out, busy_res, rd_valid, rd_data, rd_last,
                  ack_valid, slave_nack, input ready);
  modport sink (input valid, scl, sda_out, busy_res, rd_valid, rd_data, rd_last,
                ack_valid, slave_nack, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> src/i2c_register_access_master.sv
// channel | dir | payload
// req     | in  | req_type, reg_addr, wr_data, burst_len, sda_in (one half-bit tick)
// res     | out | scl, sda_out, busy_res, rd_valid, rd_data, rd_last, ack_valid, slave_nack
// cfg     | in  | data: device write address byte
//
// one registered result per request; a new request is taken every cycle unless res stalls
// the sequencer state and result register advance together on each accepted request
// results sit in one output register; a stalled result holds req.ready low only
// while it is not being taken
// synchronous reset restores idle and address 0xA6; cfg is always ready
`default_nettype none
module i2c_register_access_master #(
  parameter int MAX_BURST = i2cm_pkg::MAX_BURST_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  i2cm_req_if.sink   req,
  i2cm_res_if.source res,
  i2cm_cfg_if.sink   cfg
);

  logic [7:0] dev_addr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= i2cm_pkg::DEV_ADDR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      dev_addr <= cfg.data;
    end
  end

  i2cm_seq #(
    .MAX_BURST(MAX_BURST)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .dev_addr (dev_addr),
    .req      (req),
    .res      (res)
  );

endmodule
`default_nettype wire

>>> src/i2cm_seq.sv
`default_nettype none
module i2cm_seq #(
  parameter int MAX_BURST = i2cm_pkg::MAX_BURST_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] dev_addr,
  i2cm_req_if.sink        req,
  i2cm_res_if.source      res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_DEVW_BITS, PH_DEVW_ACK, PH_REG_BITS, PH_REG_ACK,
    PH_DATA_BITS, PH_DATA_ACK, PH_RS_LOW, PH_RSTART, PH_DEVR_BITS, PH_DEVR_ACK,
    PH_RX_BITS, PH_RX_ACK, PH_STOP, PH_STOP_END
  } phase_t;

  phase_t         phase, phase_next;
  logic           half_tick, half_tick_next;
  logic [2:0]     bit_index, bit_index_next;
  logic [7:0]     shift_byte, shift_byte_next;
  logic [3:0]     bytes_left, bytes_left_next;
  logic [1:0]     held_kind, held_kind_next;
  logic [7:0]     held_reg_addr, held_reg_addr_next;
  logic [7:0]     held_wr_data, held_wr_data_next;
  i2cm_pkg::res_t r;
  logic [3:0]     blen;
  logic           accept;
  logic           last_byte;

  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign last_byte = (bytes_left <= 4'd1);

  // burst length: zero counts as one, clipped to the bound
  always_comb begin
    blen = req.burst_len;
    if (blen == 4'd0) blen = 4'd1;
    if (32'(blen) > MAX_BURST) blen = 4'(MAX_BURST);
  end

  always_comb begin
    phase_next         = phase;
    half_tick_next     = ~half_tick;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    bytes_left_next    = bytes_left;
    held_kind_next     = held_kind;
    held_reg_addr_next = held_reg_addr;
    held_wr_data_next  = held_wr_data;
    r            = '0;
    r.scl        = 1'b1;
    r.sda_out    = 1'b1;
    r.busy_res   = 1'b1;
    case (phase)
      PH_IDLE: begin
        r.busy_res     = 1'b0;
        half_tick_next = half_tick;
        if (req.req_type != i2cm_pkg::REQ_NONE) begin
          held_kind_next     = req.req_type;
          held_reg_addr_next = req.reg_addr;
          held_wr_data_next  = req.wr_data;
          bytes_left_next    = (req.req_type == i2cm_pkg::REQ_BURST) ? blen : 4'd1;
          phase_next         = PH_START;
          half_tick_next     = 1'b0;
          bit_index_next     = 3'd0;
        end
      end
      PH_START, PH_RSTART: begin
        r.sda_out = ~half_tick;
        if (half_tick) begin
          bit_index_next = 3'd0;
          if (phase == PH_START) begin
            shift_byte_next = dev_addr;
            phase_next      = PH_DEVW_BITS;
          end else begin
            shift_byte_next = dev_addr + 8'd1;
            phase_next      = PH_DEVR_BITS;
          end
        end
      end
      PH_DEVW_BITS, PH_REG_BITS, PH_DATA_BITS, PH_DEVR_BITS: begin
        r.scl     = half_tick;
        r.sda_out = shift_byte[7];
        if (half_tick) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            case (phase)
              PH_DEVW_BITS: phase_next = PH_DEVW_ACK;
              PH_REG_BITS:  phase_next = PH_REG_ACK;
              PH_DATA_BITS: phase_next = PH_DATA_ACK;
              default:      phase_next = PH_DEVR_ACK;
            endcase
          end
        end
      end
      PH_DEVW_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK: begin
        r.scl = half_tick;
        if (half_tick) begin
          r.ack_valid    = 1'b1;
          r.slave_nack   = req.sda_in;
          bit_index_next = 3'd0;
          case (phase)
            PH_DEVW_ACK: begin
              shift_byte_next = held_reg_addr;
              phase_next      = PH_REG_BITS;
            end
            PH_REG_ACK: begin
              if (held_kind == i2cm_pkg::REQ_WRITE) begin
                shift_byte_next = held_wr_data;
                phase_next      = PH_DATA_BITS;
              end else begin
                phase_next = PH_RS_LOW;
              end
            end
            PH_DATA_ACK: phase_next = PH_STOP;
            default: begin
              shift_byte_next = 8'd0;
              phase_next      = PH_RX_BITS;
            end
          endcase
        end
      end
      PH_RS_LOW: begin
        r.scl          = 1'b0;
        phase_next     = PH_RSTART;
        half_tick_next = 1'b0;
      end
      PH_RX_BITS: begin
        r.scl = half_tick;
        if (half_tick) begin
          shift_byte_next = {shift_byte[6:0], req.sda_in};
          bit_index_next  = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            r.rd_valid = 1'b1;
            r.rd_data  = {shift_byte[6:0], req.sda_in};
            r.rd_last  = last_byte;
            phase_next = PH_RX_ACK;
          end
        end
      end
      PH_RX_ACK: begin
        // master nack on the last byte, ack otherwise
        r.scl     = half_tick;
        r.sda_out = last_byte;
        if (half_tick) begin
          if (last_byte) begin
            bytes_left_next = 4'd0;
            phase_next      = PH_STOP;
          end else begin
            bytes_left_next = bytes_left - 4'd1;
            shift_byte_next = 8'd0;
            phase_next      = PH_RX_BITS;
          end
        end
      end
      PH_STOP: begin
        r.scl     = half_tick;
        r.sda_out = 1'b0;
        if (half_tick) phase_next = PH_STOP_END;
      end
      PH_STOP_END: begin
        phase_next     = PH_IDLE;
        half_tick_next = 1'b0;
      end
      default: begin
        phase_next     = PH_IDLE;
        half_tick_next = 1'b0;
        r.busy_res     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      half_tick     <= 1'b0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      bytes_left    <= 4'd0;
      held_kind     <= 2'd0;
      held_reg_addr <= 8'd0;
      held_wr_data  <= 8'd0;
      res.valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        half_tick     <= half_tick_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        bytes_left    <= bytes_left_next;
        held_kind     <= held_kind_next;
        held_reg_addr <= held_reg_addr_next;
        held_wr_data  <= held_wr_data_next;
        res.valid     <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted tick
  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl        <= r.scl;
      res.sda_out    <= r.sda_out;
      res.busy_res   <= r.busy_res;
      res.rd_valid   <= r.rd_valid;
      res.rd_data    <= r.rd_data;
      res.rd_last    <= r.rd_last;
      res.ack_valid  <= r.ack_valid;
      res.slave_nack <= r.slave_nack;
    end
  end

endmodule
`default_nettype wire
